FILE: src/polynomial_add_sub_mul_assert.svh
// Assertion macros shared by the polynomial unit.
`ifndef POLYNOMIAL_ADD_SUB_MUL_ASSERT_SVH
`define POLYNOMIAL_ADD_SUB_MUL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PASM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PASM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/pasm_pkg.sv
// Shared types and constants of the polynomial add, subtract and multiply unit.
package pasm_pkg;

	localparam int unsigned COEFF_W = 16;
	localparam int unsigned RES_W   = 48;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned POS_W   = 6;

	typedef enum logic [2:0] {
		OP_LOAD_FIRST  = 3'd0,
		OP_LOAD_SECOND = 3'd1,
		OP_ADD         = 3'd2,
		OP_SUB         = 3'd3,
		OP_MUL         = 3'd4
	} opcode_t;

	// Register indexes of the configuration port
	localparam logic CFG_FIRST_DEGREE  = 1'b0;
	localparam logic CFG_SECOND_DEGREE = 1'b1;

	// Control broadcast to every cell of the chain
	typedef struct packed {
		logic                      en;
		logic                      clr;
		logic                      ld;
		logic [IDX_W-1:0]          ld_idx;
		logic signed [COEFF_W-1:0] ld_val;
		logic [IDX_W-1:0]          deg;
	} cell_ctl_t;

endpackage

FILE: src/pasm_cell.sv
// One cell of the transposed convolution chain: holds one first-operand coefficient.
module pasm_cell #(
	parameter int unsigned J = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pasm_pkg::cell_ctl_t                 ctl,
	input  logic signed [pasm_pkg::COEFF_W-1:0] x,
	input  logic signed [pasm_pkg::RES_W-1:0]   p_in,
	output logic signed [pasm_pkg::RES_W-1:0]   p_out
);

	logic signed [pasm_pkg::COEFF_W-1:0]   a_q;
	logic signed [pasm_pkg::COEFF_W-1:0]   a_eff;
	logic signed [2*pasm_pkg::COEFF_W-1:0] prod;
	logic signed [pasm_pkg::RES_W-1:0]     p_q;

	// Capture this cell's coefficient on a matching load
	always_ff @(posedge clk) begin
		if (ctl.ld && (ctl.ld_idx == pasm_pkg::IDX_W'(J))) begin
			a_q <= ctl.ld_val;
		end
	end

	// Coefficients past the degree read as zero
	assign a_eff = (pasm_pkg::IDX_W'(J) <= ctl.deg) ? a_q : '0;
	assign prod  = a_eff * x;

	// Accumulate the partial sum handed down from the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else if (ctl.clr) begin
			p_q <= '0;
		end else if (ctl.en) begin
			p_q <= p_in + pasm_pkg::RES_W'(prod);
		end
	end

	assign p_out = p_q;

endmodule

FILE: src/polynomial_add_sub_mul.sv
// Top level of the polynomial add, subtract and multiply unit.
//
// Input channel (in_valid / in_stall) carries opcode, coeff_index, coeff_value.
// Load items write one coefficient each. The first operand lives in a chain
// of MAX_DEGREE+1 cells, the second in a memory with a write and a read port.
// A compute item starts a run of top+1 result items, one per cycle while the
// output is not stalled, in rising result_position order; top is the larger
// degree for add/subtract and the degree sum for multiply. Each result passes
// the step counter, the s1 and s2 stage registers and the output register,
// and the next item is taken once the last result has reached the output
// register. For multiply the cell chain forms one output coefficient per step
// from one second-operand coefficient read per step from the memory port.
// Output channel (out_valid / out_stall) carries result_coeff, result_position
// and last_coeff. A stall freezes the step counter, the stage registers, the
// memory read and every cell until the result is taken. Configuration writes
// (cfg_we, cfg_index, cfg_data) set the two degrees and are made while idle by
// the user; the block does not enforce it. Reset clears the degrees, valid flags
// and cell sums; the coefficient stores are undefined until loaded.
module polynomial_add_sub_mul #(
	parameter int unsigned MAX_DEGREE = 31
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [pasm_pkg::IDX_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [2:0]                           opcode,
	input  logic [pasm_pkg::IDX_W-1:0]           coeff_index,
	input  logic signed [pasm_pkg::COEFF_W-1:0]  coeff_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pasm_pkg::RES_W-1:0]    result_coeff,
	output logic [pasm_pkg::POS_W-1:0]           result_position,
	output logic                                 last_coeff
);

	localparam int unsigned N  = MAX_DEGREE + 1;
	localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

	localparam logic [pasm_pkg::IDX_W-1:0] DMAX = pasm_pkg::IDX_W'(MAX_DEGREE);

	// Configuration
	logic [pasm_pkg::IDX_W-1:0] first_degree_q, second_degree_q;
	logic [pasm_pkg::IDX_W-1:0] d1, d2;

	// Sequencer
	logic                       accept, en, busy, is_compute;
	pasm_pkg::opcode_t          op_in, op_q;
	logic                       run_q;
	logic [pasm_pkg::POS_W-1:0] t_q, top_q, off1_q, off2_q;
	logic [pasm_pkg::POS_W-1:0] top_c;
	logic [pasm_pkg::POS_W-1:0] b_idx;
	logic [IW-1:0]              rd_addr;
	logic                       bsel_c, imp_c;

	// Second store
	logic signed [pasm_pkg::COEFF_W-1:0] mem [N];
	logic signed [pasm_pkg::COEFF_W-1:0] rd_s1;

	// Stage registers
	logic                       valid_s1, bsel_s1, imp_s1, last_s1;
	logic [pasm_pkg::POS_W-1:0] pos_s1;
	logic                       valid_s2, last_s2;
	logic [pasm_pkg::POS_W-1:0] pos_s2;
	logic signed [pasm_pkg::COEFF_W-1:0] b_s2;

	// Cell chain
	pasm_pkg::cell_ctl_t                 ctl;
	logic signed [pasm_pkg::COEFF_W-1:0] x_s1;
	logic signed [pasm_pkg::RES_W-1:0]   p [N];
	logic signed [pasm_pkg::RES_W-1:0]   b_ext, res_c;

	// Output register
	logic                              out_valid_q;
	logic signed [pasm_pkg::RES_W-1:0] result_q;
	logic [pasm_pkg::POS_W-1:0]        pos_q;
	logic                              last_q;

	// Write the degree registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_degree_q  <= '0;
			second_degree_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pasm_pkg::CFG_FIRST_DEGREE:  first_degree_q  <= cfg_data;
				pasm_pkg::CFG_SECOND_DEGREE: second_degree_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp degrees to the store depth
	assign d1 = (first_degree_q > DMAX) ? DMAX : first_degree_q;
	assign d2 = (second_degree_q > DMAX) ? DMAX : second_degree_q;

	// Handshake and pipeline advance
	assign op_in    = pasm_pkg::opcode_t'(opcode);
	assign busy     = run_q | valid_s1 | valid_s2;
	assign in_stall = busy;
	assign accept   = in_valid & ~busy;
	assign en       = ~(out_valid_q & out_stall);

	// Result length of the incoming compute item
	always_comb begin
		is_compute = 1'b0;
		top_c      = '0;
		case (op_in) inside
			pasm_pkg::OP_ADD, pasm_pkg::OP_SUB: begin
				is_compute = 1'b1;
				top_c      = (d1 > d2) ? {1'b0, d1} : {1'b0, d2};
			end
			pasm_pkg::OP_MUL: begin
				is_compute = 1'b1;
				top_c      = {1'b0, d1} + {1'b0, d2};
			end
			default: ;
		endcase
	end

	// Start, count and end a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			t_q   <= '0;
		end else if (accept && is_compute) begin
			run_q <= 1'b1;
			t_q   <= '0;
		end else if (en && run_q) begin
			t_q <= t_q + 1'b1;
			if (t_q == top_q) begin
				run_q <= 1'b0;
			end
		end
	end

	// Hold the run parameters
	always_ff @(posedge clk) begin
		if (accept && is_compute) begin
			op_q   <= op_in;
			top_q  <= top_c;
			off1_q <= top_c - {1'b0, d1};
			off2_q <= top_c - {1'b0, d2};
		end
	end

	// Pick the second-operand coefficient and the impulse for this step
	assign b_idx = (op_q == pasm_pkg::OP_MUL) ? t_q : (t_q - off2_q);
	assign rd_addr = b_idx[IW-1:0];
	always_comb begin
		if (op_q == pasm_pkg::OP_MUL) begin
			bsel_c = (t_q <= {1'b0, d2});
			imp_c  = 1'b0;
		end else begin
			bsel_c = (t_q >= off2_q);
			imp_c  = (t_q == off1_q);
		end
	end

	// Second store: write on load, read one entry per step
	always_ff @(posedge clk) begin
		if (accept && (op_in == pasm_pkg::OP_LOAD_SECOND) && (coeff_index <= DMAX)) begin
			mem[coeff_index[IW-1:0]] <= coeff_value;
		end
		if (en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// Advance stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= run_q;
			valid_s2 <= valid_s1;
		end
	end

	// Advance stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			bsel_s1 <= bsel_c;
			imp_s1  <= imp_c;
			pos_s1  <= t_q;
			last_s1 <= (t_q == top_q);
			b_s2    <= (valid_s1 && bsel_s1) ? rd_s1 : '0;
			pos_s2  <= pos_s1;
			last_s2 <= last_s1;
		end
	end

	// Feed the chain: second operand for multiply, a delayed impulse otherwise
	always_comb begin
		x_s1 = '0;
		if (valid_s1) begin
			if (op_q == pasm_pkg::OP_MUL) begin
				x_s1 = bsel_s1 ? rd_s1 : '0;
			end else begin
				x_s1 = imp_s1 ? pasm_pkg::COEFF_W'(1) : '0;
			end
		end
	end

	// Broadcast control to the cells
	always_comb begin
		ctl.en     = en;
		ctl.clr    = accept & is_compute;
		ctl.ld     = accept & (op_in == pasm_pkg::OP_LOAD_FIRST);
		ctl.ld_idx = coeff_index;
		ctl.ld_val = coeff_value;
		ctl.deg    = d1;
	end

	// Chain of cells, partial sums flow toward cell zero
	for (genvar j = 0; j < N; j++) begin : g_cell
		logic signed [pasm_pkg::RES_W-1:0] p_nb;
		if (j == N - 1) begin : g_end
			assign p_nb = '0;
		end else begin : g_mid
			assign p_nb = p[j+1];
		end
		pasm_cell #(.J(j)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.x     (x_s1),
			.p_in  (p_nb),
			.p_out (p[j])
		);
	end

	// Combine the chain output with the second operand
	assign b_ext = pasm_pkg::RES_W'(b_s2);
	always_comb begin
		case (op_q)
			pasm_pkg::OP_ADD: res_c = p[0] + b_ext;
			pasm_pkg::OP_SUB: res_c = p[0] - b_ext;
			default:          res_c = p[0];
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			result_q <= res_c;
			pos_q    <= pos_s2;
			last_q   <= last_s2;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_coeff    = result_q;
	assign result_position = pos_q;
	assign last_coeff      = last_q;

	`include "polynomial_add_sub_mul_assert.svh"

	`PASM_ASSERT_NEXT(a_run_starts, accept && is_compute, run_q && (t_q == '0), "compute item did not start a run")
	`PASM_ASSERT_NOW(a_count_bound, run_q, t_q <= top_q, "step counter ran past the result length")
	`PASM_ASSERT_NEXT(a_stall_freezes, out_valid && out_stall && run_q, $stable(t_q), "sequencer moved while output stalled")
	`PASM_ASSERT_NOW(a_no_accept_busy, run_q || valid_s1 || valid_s2, !accept, "item accepted during a run")

endmodule
